// ----- rtl/nwg_pkg.sv -----
// Shared types and constants for the note waveform generator.
// Holds the note period table, the sine table, register indexes and wave shape codes.
// No dependencies.
package nwg_pkg;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_NOTE_SELECT  = 2'd0,
    REG_WAVE_SHAPE   = 2'd1,
    REG_UPPER_OCTAVE = 2'd2,
    REG_NONE         = 2'd3
  } reg_index_t;

  // Wave shape codes
  typedef enum logic [1:0] {
    SHAPE_SQUARE   = 2'd0,
    SHAPE_TRIANGLE = 2'd1,
    SHAPE_SINE     = 2'd2,
    SHAPE_HOLD     = 2'd3
  } shape_t;

  localparam int NOTE_W     = 4;
  localparam int TICK_W     = 14;
  localparam int SAMPLE_W   = 8;
  localparam int TABLE_W    = 5;
  localparam int NOTE_COUNT = 8;
  localparam logic [NOTE_W-1:0] NOTE_LAST = 4'd7;

  // Note periods in ticks, C4 up to C5
  localparam logic [TICK_W-1:0] NOTE_PERIOD [NOTE_COUNT] = '{
    14'd15287, 14'd13620, 14'd12133, 14'd11452,
    14'd10203, 14'd9089,  14'd8098,  14'd7643
  };

  // Two sine cycles in 32 steps
  localparam logic [SAMPLE_W-1:0] SINE_TABLE [32] = '{
    8'd128, 8'd176, 8'd218, 8'd246, 8'd255, 8'd246, 8'd218, 8'd176,
    8'd128, 8'd79,  8'd37,  8'd9,   8'd0,   8'd9,   8'd37,  8'd79,
    8'd127, 8'd176, 8'd218, 8'd246, 8'd255, 8'd246, 8'd218, 8'd176,
    8'd128, 8'd79,  8'd37,  8'd9,   8'd0,   8'd9,   8'd37,  8'd79
  };

  // Live configuration handed to the datapath
  typedef struct packed {
    logic [NOTE_W-1:0] note_select;
    shape_t            wave_shape;
    logic              upper_octave;
  } cfg_t;

endpackage

// ----- rtl/nwg_regs.sv -----
// Configuration register file with an APB-style port.
// Produces the live configuration and a phase clear on every register write.
// Depends on nwg_pkg.
module nwg_regs (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  output nwg_pkg::cfg_t cfg,
  output logic         cfg_clear
);
  import nwg_pkg::*;

  logic       wr_beat;
  reg_index_t wr_index;

  assign pready   = 1'b1;
  assign wr_beat  = psel && penable && pwrite;
  assign wr_index = reg_index_t'(paddr[3:2]);

  // Clear the wave phase on any write that hits a register
  always_comb begin
    cfg_clear = 1'b0;
    if (wr_beat) begin
      case (wr_index)
        REG_NOTE_SELECT, REG_WAVE_SHAPE, REG_UPPER_OCTAVE: cfg_clear = 1'b1;
        default: cfg_clear = 1'b0;
      endcase
    end
  end

  // Hold the registers, update on a write beat
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.note_select  <= 4'd8;
      cfg.wave_shape   <= SHAPE_SQUARE;
      cfg.upper_octave <= 1'b0;
    end else if (wr_beat) begin
      case (wr_index)
        REG_NOTE_SELECT:  cfg.note_select  <= pwdata[NOTE_W-1:0];
        REG_WAVE_SHAPE:   cfg.wave_shape   <= shape_t'(pwdata[1:0]);
        REG_UPPER_OCTAVE: cfg.upper_octave <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (wr_index)
      REG_NOTE_SELECT:  prdata = {28'd0, cfg.note_select};
      REG_WAVE_SHAPE:   prdata = {30'd0, cfg.wave_shape};
      REG_UPPER_OCTAVE: prdata = {31'd0, cfg.upper_octave};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

// ----- rtl/nwg_divider.sv -----
// Tick divider: counts ticks up to the note's compare value and flags each wrap.
// Compare value comes from the note period table, scaled by wave shape and octave.
// Depends on nwg_pkg.
module nwg_divider #(
  parameter int TRI_STEPS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  nwg_pkg::cfg_t cfg,
  input  logic          cfg_clear,
  input  logic          beat,
  input  logic          restart,
  output logic          wrap
);
  import nwg_pkg::*;

  // Triangle compare bases, worked out at elaboration
  localparam logic [TICK_W-1:0] TRI_PERIOD [NOTE_COUNT] = '{
    TICK_W'(15287 / TRI_STEPS), TICK_W'(13620 / TRI_STEPS),
    TICK_W'(12133 / TRI_STEPS), TICK_W'(11452 / TRI_STEPS),
    TICK_W'(10203 / TRI_STEPS), TICK_W'(9089 / TRI_STEPS),
    TICK_W'(8098 / TRI_STEPS),  TICK_W'(7643 / TRI_STEPS)
  };

  logic [TICK_W-1:0] tick_count;
  logic [TICK_W-1:0] tick_count_next;
  logic [TICK_W-1:0] period;
  logic [TICK_W-1:0] compare;
  logic [2:0]        note;
  logic              active;

  assign note   = cfg.note_select[2:0];
  assign active = (cfg.note_select <= NOTE_LAST);

  // Scale the note period to the compare value
  always_comb begin
    case (cfg.wave_shape)
      SHAPE_TRIANGLE: period = TRI_PERIOD[note];
      SHAPE_SINE:     period = NOTE_PERIOD[note] >> 4;
      default:        period = NOTE_PERIOD[note];
    endcase
    if (cfg.upper_octave) period = period >> 1;
    compare = (period != '0) ? period - TICK_W'(1) : '0;
  end

  assign wrap = beat && !restart && active && (tick_count >= compare);

  // Advance or clear the counter
  always_comb begin
    tick_count_next = tick_count;
    if (cfg_clear || (beat && restart)) begin
      tick_count_next = '0;
    end else if (beat && active) begin
      tick_count_next = wrap ? '0 : tick_count + TICK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else begin
      tick_count <= tick_count_next;
    end
  end

endmodule

// ----- rtl/nwg_shaper.sv -----
// Waveform state: square, triangle and sine amplitude, plus the held sample.
// The amplitude is kept as quotient and remainder of level over TRI_STEPS.
// Depends on nwg_pkg.
module nwg_shaper #(
  parameter int TRI_STEPS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  nwg_pkg::shape_t               wave_shape,
  input  logic                          clear,
  input  logic                          wrap,
  output logic [nwg_pkg::SAMPLE_W-1:0]  held_next
);
  import nwg_pkg::*;

  localparam int R_W = $clog2(TRI_STEPS);
  localparam int Q_W = 10;
  localparam logic [R_W:0]   STEPS  = (R_W+1)'(TRI_STEPS);
  localparam logic [Q_W-1:0] STEP_Q = Q_W'(256 / TRI_STEPS);
  localparam logic [R_W-1:0] STEP_R = R_W'(256 % TRI_STEPS);

  logic [SAMPLE_W-1:0] amp_q, amp_q_next;
  logic [R_W-1:0]      amp_r, amp_r_next;
  logic                rising, rising_next;
  logic [TABLE_W-1:0]  table_index, table_index_next;
  logic [SAMPLE_W-1:0] held_output;

  logic [Q_W-1:0] q_w;
  logic [R_W:0]   r_sum;
  logic           r_carry;
  logic [R_W-1:0] r_up;
  logic [Q_W-1:0] q_up;
  logic           r_borrow;
  logic [R_W-1:0] r_dn;
  logic [Q_W-1:0] q_dn;
  logic           below;
  logic [R_W:0]   r_twice;

  assign q_w = Q_W'(amp_q);

  // Ramp arithmetic in quotient/remainder form
  always_comb begin
    r_sum    = {1'b0, amp_r} + {1'b0, STEP_R};
    r_carry  = (r_sum >= STEPS);
    r_up     = r_carry ? R_W'(r_sum - STEPS) : r_sum[R_W-1:0];
    q_up     = q_w + STEP_Q + Q_W'(r_carry);
    below    = (q_w < STEP_Q) || ((q_w == STEP_Q) && (amp_r < STEP_R));
    r_borrow = (amp_r < STEP_R);
    r_dn     = r_borrow ? R_W'({1'b0, amp_r} + STEPS - {1'b0, STEP_R})
                        : amp_r - STEP_R;
    q_dn     = q_w - STEP_Q - Q_W'(r_borrow);
  end

  // Step the wave on a wrap, drop the phase on a clear
  always_comb begin
    amp_q_next       = amp_q;
    amp_r_next       = amp_r;
    rising_next      = rising;
    table_index_next = table_index;
    if (clear) begin
      amp_q_next       = '0;
      amp_r_next       = '0;
      rising_next      = 1'b1;
      table_index_next = '0;
    end else if (wrap) begin
      case (wave_shape)
        SHAPE_SQUARE: begin
          if (amp_r == '0) begin
            amp_q_next = 8'd255 - amp_q;
            amp_r_next = '0;
          end else if (amp_q == 8'd255) begin
            amp_q_next = '0;
            amp_r_next = '0;
          end else begin
            amp_q_next = 8'd254 - amp_q;
            amp_r_next = R_W'(STEPS - {1'b0, amp_r});
          end
        end
        SHAPE_TRIANGLE: begin
          if (rising) begin
            if ((q_up > Q_W'(254)) || ((q_up == Q_W'(254)) && (r_up != '0))) begin
              amp_q_next  = 8'd255;
              amp_r_next  = '0;
              rising_next = 1'b0;
            end else begin
              amp_q_next = q_up[SAMPLE_W-1:0];
              amp_r_next = r_up;
            end
          end else if (below || (q_dn == '0)) begin
            amp_q_next  = '0;
            amp_r_next  = '0;
            rising_next = 1'b1;
          end else begin
            amp_q_next = q_dn[SAMPLE_W-1:0];
            amp_r_next = r_dn;
          end
        end
        SHAPE_SINE: begin
          table_index_next = table_index + TABLE_W'(1);
          amp_q_next       = SINE_TABLE[table_index + TABLE_W'(1)];
          amp_r_next       = '0;
        end
        default: ;
      endcase
    end
  end

  // Round the amplitude to nearest, ties upward
  assign r_twice   = {amp_r_next, 1'b0};
  assign held_next = (wrap && !clear) ? amp_q_next + SAMPLE_W'(r_twice >= STEPS)
                                      : held_output;

  always_ff @(posedge clk) begin
    if (rst) begin
      amp_q       <= '0;
      amp_r       <= '0;
      rising      <= 1'b1;
      table_index <= '0;
      held_output <= '0;
    end else begin
      amp_q       <= amp_q_next;
      amp_r       <= amp_r_next;
      rising      <= rising_next;
      table_index <= table_index_next;
      held_output <= held_next;
    end
  end

endmodule

// ----- rtl/note_waveform_generator.sv -----
// Top level of the note waveform generator: registers, divider, shaper, result register.
// Depends on nwg_pkg, nwg_regs, nwg_divider and nwg_shaper.
//
// Usage:
//   Tick channel (tick_valid/tick_ready, restart): one beat per system tick.
//   restart=1 clears the divider and wave phase; that tick is not counted.
//   Result channel (result_valid/result_ready, sample, updated): one beat per
//   tick beat; updated=1 marks a tick on which the wave stepped.
//   Configuration: APB-style port, note_select at 0x0, wave_shape at 0x4,
//   upper_octave at 0x8. Any register write clears the wave phase.
// Timing:
//   The result is valid in the cycle after the tick beat. Throughput is
//   one beat per cycle unless stalled: the whole wave step is done between
//   the state registers and the result register. A new tick is taken
//   whenever the result register is empty or being drained in the same cycle.
// Reset:
//   Silent note, square shape, lower octave, held sample 0, result register empty.
// Stall:
//   While result_ready is low and a result waits, tick_ready is low; the
//   divider and wave state hold unless a register write clears the phase.
module note_waveform_generator #(
  parameter int TRI_STEPS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        tick_valid,
  output logic        tick_ready,
  input  logic        restart,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [7:0]  sample,
  output logic        updated,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import nwg_pkg::*;

  cfg_t                cfg;
  logic                cfg_clear;
  logic                beat;
  logic                wrap;
  logic                phase_clear;
  logic [SAMPLE_W-1:0] held_next;

  assign tick_ready  = !result_valid || result_ready;
  assign beat        = tick_valid && tick_ready;
  assign phase_clear = cfg_clear || (beat && restart);

  nwg_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg      (cfg),
    .cfg_clear(cfg_clear)
  );

  nwg_divider #(.TRI_STEPS(TRI_STEPS)) u_divider (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cfg_clear(cfg_clear),
    .beat     (beat),
    .restart  (restart),
    .wrap     (wrap)
  );

  nwg_shaper #(.TRI_STEPS(TRI_STEPS)) u_shaper (
    .clk       (clk),
    .rst       (rst),
    .wave_shape(cfg.wave_shape),
    .clear     (phase_clear),
    .wrap      (wrap),
    .held_next (held_next)
  );

  // Result register: load on a tick beat, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (beat) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat) begin
      sample  <= held_next;
      updated <= wrap;
    end
  end

endmodule
